>>> src/lti_pkg.sv
// Package: constants, types and helpers for the lower triangular inverse block.
package lti_pkg;
   localparam int MAX_ORDER = 8;
   localparam int TRI_DEPTH = MAX_ORDER * (MAX_ORDER + 1) / 2;
   localparam int ADDR_W = $clog2(TRI_DEPTH);
   localparam int IDX_W = 3;
   localparam int SIZE_W = 4;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

   typedef enum logic [10:0] {
      ST_IDLE    = 11'b00000000001,
      ST_DIAG_RD = 11'b00000000010,
      ST_DIV     = 11'b00000000100,
      ST_DIAG_WR = 11'b00000001000,
      ST_MAC_RD  = 11'b00000010000,
      ST_MAC_WT  = 11'b00000100000,
      ST_MAC_ACC = 11'b00001000000,
      ST_SCALE   = 11'b00010000000,
      ST_SCALE2  = 11'b00100000000,
      ST_EMIT_RD = 11'b01000000000,
      ST_EMIT    = 11'b10000000000
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic             load_wr;      // store the incoming word
      logic             clr_flag;     // start of an inversion
      logic [ADDR_W-1:0] m_addr;      // matrix read address
      logic [ADDR_W-1:0] v_addr;      // inverse read address
      logic [ADDR_W-1:0] w_addr;      // inverse write address
      logic             div_start;
      logic             diag_wr;      // write reciprocal
      logic             acc_clr;
      logic             acc_en;
      logic             scale1;       // first partial product of scaling
      logic             scale2;       // finish scaling and write
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } stat_type;

   function automatic logic [ADDR_W-1:0] tri_at(input logic [IDX_W-1:0] r,
                                                input logic [IDX_W-1:0] c);
      logic [ADDR_W+3:0] t;
      t = ({3'b0, r} * ({3'b0, r} + 6'd1)) >> 1;
      return ADDR_W'(t + {{(ADDR_W+1){1'b0}}, c});
   endfunction
endpackage

>>> src/lti_ram.sv
// Generic single write port RAM with registered read.
module lti_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 36
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

>>> src/lti_div.sv
// Radix-2 restoring divider: rounded 2^32 / d (on |d|, sign restored) with saturation.
module lti_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] d,
   output logic               done,
   output logic signed [31:0] q
);
   logic [33:0] rem_ff, rem_in;
   logic [33:0] quo_ff, quo_in;
   logic [31:0] mag_ff, mag_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic [33:0] trial;
   logic [34:0] rq;
   logic [33:0] num;

   // numerator 2^33 + |d| gives quotient of (2^32 + |d|/2)*2 / |d|, rounded by halving
   always_comb begin
      rem_in = rem_ff; quo_in = quo_ff; mag_in = mag_ff; neg_in = neg_ff;
      cnt_in = cnt_ff; run_in = run_ff; done = 1'b0;
      num = 34'h2_0000_0000 + {2'b0, mag_ff};
      trial = {rem_ff[32:0], num[6'd33 - cnt_ff]};
      if (start) begin
         mag_in = d[31] ? 32'(-d) : d;
         neg_in = d[31];
         rem_in = '0; quo_in = '0; cnt_in = '0; run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {2'b0, mag_ff}) begin
            rem_in = trial - {2'b0, mag_ff};
            quo_in = {quo_ff[32:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[32:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd33) begin
            run_in = 1'b0;
            done = 1'b1;
         end
      end
      // quotient of (2^33+m)/m = 2*(2^32/m)+1 floored; floor(that)/2 = rounded
      rq = {1'b0, quo_in} >> 1;
      if (neg_ff) q = (rq > 35'h0_8000_0000) ? 32'sh8000_0000 : 32'(-rq);
      else        q = (rq > 35'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : rq[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
      rem_ff <= rem_in; quo_ff <= quo_in; mag_ff <= mag_in;
      neg_ff <= neg_in; cnt_ff <= cnt_in;
   end
endmodule

>>> src/lti_datapath.sv
// Datapath: matrix and inverse stores, divider, multiply-accumulate and scaling.
module lti_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  lti_pkg::cmd_type              cmd,
   output lti_pkg::stat_type             stat,
   input  logic [lti_pkg::ADDR_W-1:0]    load_addr,
   input  logic signed [31:0]            load_value,
   output logic signed [31:0]            inv_word,
   output logic                          flag
);
   import lti_pkg::*;

   logic signed [31:0] m_rd, v_rd, q;
   logic signed [31:0] dinv_ff, dinv_in;
   logic signed [52:0] acc_ff, acc_in;
   logic               flag_ff, flag_in;
   logic [63:0]        prod;
   logic [47:0]        pr;
   logic [51:0]        ms;
   logic [31:0]        md;
   logic [63:0]        hi_ff, hi_in;
   logic [63:0]        lo;
   logic [63:0]        r;
   logic               neg;
   logic signed [31:0] scaled;
   logic               wr_en;
   logic signed [31:0] wr_data;

   lti_ram #(.WIDTH(32), .DEPTH(TRI_DEPTH)) u_mat (
      .clock(clock), .wr_en(cmd.load_wr), .wr_addr(load_addr), .wr_data(load_value),
      .rd_addr(cmd.m_addr), .rd_data(m_rd));
   lti_ram #(.WIDTH(32), .DEPTH(TRI_DEPTH)) u_inv (
      .clock(clock), .wr_en(wr_en), .wr_addr(cmd.w_addr), .wr_data(wr_data),
      .rd_addr(cmd.v_addr), .rd_data(v_rd));
   lti_div u_div (.clock(clock), .reset(reset), .start(cmd.div_start), .d(m_rd),
      .done(stat.div_done), .q(q));

   always_comb begin
      dinv_in = dinv_ff; acc_in = acc_ff; flag_in = flag_ff; hi_in = hi_ff;
      // magnitudes are zero-extended so that -2^31 gives 2^31
      prod = 64'($unsigned(m_rd[31] ? -m_rd : m_rd)) *
             64'($unsigned(v_rd[31] ? -v_rd : v_rd));
      pr = 48'((prod + 64'h8000) >> 16);
      ms = acc_ff[52] ? 52'(-acc_ff) : acc_ff[51:0];
      md = dinv_ff[31] ? 32'(-dinv_ff) : dinv_ff;
      neg = ~(acc_ff[52] ^ dinv_ff[31]);
      lo = 64'(ms[31:0]) * 64'(md);
      r = ((hi_ff << 32) + lo + 64'h8000) >> 16;
      if (hi_ff >= 64'h1_0000) scaled = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      else if (neg) scaled = (r > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-r);
      else scaled = (r > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : r[31:0];
      if (cmd.clr_flag) flag_in = 1'b0;
      if (cmd.div_start && m_rd == 32'sd0) flag_in = 1'b1;
      if (cmd.diag_wr) dinv_in = q;
      if (cmd.acc_clr) acc_in = '0;
      else if (cmd.acc_en)
         acc_in = (m_rd[31] ^ v_rd[31]) ? acc_ff - 53'(pr) : acc_ff + 53'(pr);
      if (cmd.scale1) hi_in = 64'(ms[51:32]) * 64'(md);
      wr_en = cmd.diag_wr | cmd.scale2;
      wr_data = cmd.diag_wr ? q : scaled;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= 1'b0;
      end else begin
         flag_ff <= flag_in;
      end
      dinv_ff <= dinv_in; acc_ff <= acc_in; hi_ff <= hi_in;
   end

   assign inv_word = v_rd;
   assign flag = flag_ff;
endmodule

>>> src/lti_ctrl.sv
// Controller: sequences loading, row-by-row inversion and emission.
module lti_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [2:0]                 row_index,
   input  logic [2:0]                 col_index,
   input  logic                       last_element,
   input  logic [lti_pkg::SIZE_W-1:0] size,
   input  lti_pkg::stat_type          stat,
   output lti_pkg::cmd_type           cmd,
   output logic [lti_pkg::ADDR_W-1:0] load_addr,
   output logic                       busy,
   output logic                       emit,
   output logic [2:0]                 e_row,
   output logic [2:0]                 e_col,
   output logic                       e_last
);
   import lti_pkg::*;

   state_type  st_ff, st_in;
   logic [2:0] i_ff, i_in, j_ff, j_in, k_ff, k_in, n1_ff, n1_in;
   logic [2:0] er_ff, er_in;

   assign busy = (st_ff != ST_IDLE);
   assign load_addr = tri_at(row_index, col_index);

   always_comb begin
      st_in = st_ff; i_in = i_ff; j_in = j_ff; k_in = k_ff; n1_in = n1_ff;
      er_in = er_ff;
      cmd = '0;
      emit = 1'b0;
      cmd.m_addr = tri_at(i_ff, i_ff);
      cmd.v_addr = tri_at(i_ff, j_ff);
      cmd.w_addr = tri_at(i_ff, j_ff);
      e_row = i_ff; e_col = er_ff; e_last = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load_wr = (col_index <= row_index);
               if (last_element) begin
                  cmd.clr_flag = 1'b1;
                  n1_in = (size == '0) ? 3'd0 : (size > SIZE_W'(MAX_ORDER)) ?
                          3'(MAX_ORDER - 1) : 3'(size - 4'd1);
                  i_in = '0;
                  st_in = ST_DIAG_RD;
               end
            end
         end
         ST_DIAG_RD: st_in = ST_DIV;
         ST_DIV: begin
            cmd.div_start = 1'b1;
            st_in = ST_DIAG_WR;
         end
         ST_DIAG_WR: begin
            cmd.w_addr = tri_at(i_ff, i_ff);
            if (stat.div_done) begin
               cmd.diag_wr = 1'b1;
               j_in = '0;
               er_in = '0;
               st_in = (i_ff == 3'd0) ? ST_EMIT_RD : ST_MAC_RD;
               k_in = '0;
            end
         end
         ST_MAC_RD: begin
            cmd.acc_clr = 1'b1;
            k_in = j_ff;
            cmd.m_addr = tri_at(i_ff, j_ff);
            cmd.v_addr = tri_at(j_ff, j_ff);
            st_in = ST_MAC_WT;
         end
         ST_MAC_WT: begin
            // read of term k lands; issue next
            cmd.acc_en = 1'b1;
            k_in = k_ff + 3'd1;
            cmd.m_addr = tri_at(i_ff, k_in);
            cmd.v_addr = tri_at(k_in, j_ff);
            if (k_in == i_ff) st_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale1 = 1'b1;
            st_in = ST_SCALE2;
         end
         ST_SCALE2: begin
            cmd.scale2 = 1'b1;
            j_in = j_ff + 3'd1;
            st_in = (j_in == i_ff) ? ST_EMIT_RD : ST_MAC_RD;
         end
         ST_EMIT_RD: begin
            cmd.v_addr = tri_at(i_ff, er_ff);
            st_in = ST_EMIT;
         end
         ST_EMIT: begin
            emit = 1'b1;
            e_last = (er_ff == i_ff) && (i_ff == n1_ff);
            er_in = er_ff + 3'd1;
            cmd.v_addr = tri_at(i_ff, er_in);
            if (er_ff == i_ff) begin
               if (i_ff == n1_ff) st_in = ST_IDLE;
               else begin
                  i_in = i_ff + 3'd1;
                  st_in = ST_DIAG_RD;
               end
            end
         end
         ST_MAC_ACC: st_in = ST_SCALE;
         default: st_in = ST_IDLE;
      endcase
      if (st_ff == ST_DIAG_RD) cmd.m_addr = tri_at(i_ff, i_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
      i_ff <= i_in; j_ff <= j_in; k_ff <= k_in; n1_ff <= n1_in; er_ff <= er_in;
   end
endmodule

>>> src/lower_triangular_inverse.sv
// Lower triangular inverse: loads the lower triangle, inverts, emits the inverse.
// Loading: one word per cycle while busy is low; a word marked last starts inversion.
// Row i: reciprocal in the radix-2 divider, then a multiply-accumulate and scaling per
// off-diagonal entry, then the row is emitted; the receiver cannot stall.
// Busy stays high from the last loaded word until the controller emits the final entry.
// Synchronous active-high reset clears control and the flag; stores are not cleared.
module lower_triangular_inverse (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [2:0]                 req_row_index,
   input  logic [2:0]                 req_col_index,
   input  logic signed [31:0]         req_element_value,
   input  logic                       req_last_element,
   input  logic                       csr_wr_en,
   input  logic [lti_pkg::SIZE_W-1:0] csr_wr_data,
   output logic                       rsp_strobe,
   output logic [2:0]                 rsp_out_row,
   output logic [2:0]                 rsp_out_col,
   output logic signed [31:0]         rsp_out_value,
   output logic                       rsp_zero_pivot,
   output logic                       rsp_last_result
);
   import lti_pkg::*;

   logic [SIZE_W-1:0] size_ff, size_in;
   cmd_type           cmd;
   stat_type          stat;
   logic [ADDR_W-1:0] load_addr;
   logic              emit, e_last, flag;
   logic [2:0]        e_row, e_col;
   logic signed [31:0] inv_word;
   // output word register
   logic               str_ff;
   logic [2:0]         row_ff, col_ff;
   logic               lst_ff;
   logic signed [31:0] val_ff;

   assign size_in = csr_wr_en ? csr_wr_data : size_ff;

   lti_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .row_index(req_row_index),
      .col_index(req_col_index), .last_element(req_last_element), .size(size_ff),
      .stat(stat), .cmd(cmd), .load_addr(load_addr), .busy(busy), .emit(emit),
      .e_row(e_row), .e_col(e_col), .e_last(e_last));

   lti_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat), .load_addr(load_addr),
      .load_value(req_element_value), .inv_word(inv_word), .flag(flag));

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
         str_ff  <= 1'b0;
      end else begin
         size_ff <= size_in;
         str_ff  <= emit;
      end
      row_ff <= e_row; col_ff <= e_col; lst_ff <= e_last; val_ff <= inv_word;
   end

   // read data for the emitted entry is valid in the emit cycle; register it
   // together with its position
   assign rsp_strobe      = str_ff;
   assign rsp_out_row     = row_ff;
   assign rsp_out_col     = col_ff;
   assign rsp_out_value   = val_ff;
   assign rsp_zero_pivot  = flag;
   assign rsp_last_result = lst_ff;

`ifndef NO_ASSERTIONS
   a_last_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_last_result |-> rsp_strobe) else $error("last without strobe");
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !busy |=> !rsp_strobe || $past(emit)) else $error("strobe while idle");
   a_last_done: assert property (@(posedge clock) disable iff (reset)
      rsp_last_result |-> !busy) else $error("busy after last word");
`endif
endmodule

>>> dv/testbench.sv
// Testbench for the lower triangular inverse block: directed table, then random matrices.
`timescale 1ns / 1ps

module testbench;
   import lti_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 600;
   localparam int N_DIRECTED     = 12;

   // One loaded word. When check is set, the row carries a typed-in expectation
   // for the first inverse entry (row 0, col 0).
   typedef struct {
      logic [2:0]  row;
      logic [2:0]  col;
      logic [31:0] value;
      logic        last;
      logic        check;
      logic [31:0] exp_value;
      logic        exp_zero;
   } stim_row_type;

   typedef struct {
      logic [2:0]  row;
      logic [2:0]  col;
      logic [31:0] value;
      logic        zero;
      logic        last;
   } inv_word_type;

   logic clock, reset, start, busy;
   logic [2:0] req_row_index, req_col_index;
   logic signed [31:0] req_element_value;
   logic req_last_element;
   logic csr_wr_en;
   logic [SIZE_W-1:0] csr_wr_data;
   logic rsp_strobe;
   logic [2:0] rsp_out_row, rsp_out_col;
   logic signed [31:0] rsp_out_value;
   logic rsp_zero_pivot, rsp_last_result;

   lower_triangular_inverse dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_row_index(req_row_index), .req_col_index(req_col_index),
      .req_element_value(req_element_value), .req_last_element(req_last_element),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .rsp_strobe(rsp_strobe), .rsp_out_row(rsp_out_row), .rsp_out_col(rsp_out_col),
      .rsp_out_value(rsp_out_value), .rsp_zero_pivot(rsp_zero_pivot),
      .rsp_last_result(rsp_last_result)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // predictor state: its own copy of both triangles and the size register
   logic signed [63:0] mat_copy [TRI_DEPTH];
   logic signed [63:0] inv_copy [TRI_DEPTH];
   logic [SIZE_W-1:0]  order_reg;
   inv_word_type       inverse_queue[$];
   logic [31:0]        typed_value_q[$];   // typed-in values for the (0,0) word
   logic               typed_zero_q[$];
   logic               typed_valid_q[$];
   int errors, words_loaded, inverses_done, results_seen, idle_cycles;
   int send_idle_pct;

   localparam logic signed [63:0] QMAX = 64'sd2147483647;
   localparam logic signed [63:0] QMIN = -64'sd2147483648;

   function automatic int tri_pos(int r, int c);
      return r * (r + 1) / 2 + c;
   endfunction

   function automatic logic [63:0] magnitude(logic signed [63:0] v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic signed [63:0] clamp_q(logic [63:0] mag, logic neg);
      if (neg) return mag > 64'h8000_0000 ? QMIN : -$signed(mag);
      return mag > 64'h7FFF_FFFF ? QMAX : $signed(mag);
   endfunction

   // reciprocal of the raw diagonal, 2^32/d, rounded half away from zero
   function automatic logic signed [63:0] reciprocal(logic signed [63:0] d);
      logic [63:0] m;
      m = magnitude(d);
      return clamp_q(((64'd1 << 32) + m / 2) / m, d < 0);
   endfunction

   function automatic logic signed [63:0] mul_round(logic signed [63:0] a,
                                                    logic signed [63:0] b);
      logic [63:0] m;
      logic signed [63:0] r;
      m = magnitude(a) * magnitude(b);
      r = $signed((m + 64'h8000) >> 16);
      return ((a < 0) != (b < 0)) ? -r : r;
   endfunction

   // -(s*d) rounded and saturated; 128-bit product avoids overflow
   function automatic logic signed [63:0] neg_scale(logic signed [63:0] s,
                                                    logic signed [63:0] d);
      logic [127:0] p;
      logic neg;
      neg = !((s < 0) != (d < 0));
      p = (128'(magnitude(s)) * 128'(magnitude(d)) + 128'h8000) >> 16;
      if (p > 128'h8000_0000) return neg ? QMIN : QMAX;
      return clamp_q(p[63:0], neg);
   endfunction

   // store one word and, on last, compute and queue the whole inverse
   task automatic predict_inverse(stim_row_type w);
      int n;
      logic zflag;
      logic signed [63:0] dinv, acc;
      if (w.col <= w.row)
         mat_copy[tri_pos(w.row, w.col)] = $signed({{32{w.value[31]}}, w.value});
      if (!w.last) return;
      n = order_reg == 0 ? 1 : (order_reg > MAX_ORDER ? MAX_ORDER : int'(order_reg));
      zflag = 1'b0;
      for (int i = 0; i < n; i++) begin
         if (mat_copy[tri_pos(i, i)] == 0) begin
            zflag = 1'b1;
            dinv = QMAX;
         end else begin
            dinv = reciprocal(mat_copy[tri_pos(i, i)]);
         end
         inv_copy[tri_pos(i, i)] = dinv;
         for (int j = 0; j < i; j++) begin
            acc = 0;
            for (int k = j; k < i; k++)
               acc += mul_round(mat_copy[tri_pos(i, k)], inv_copy[tri_pos(k, j)]);
            inv_copy[tri_pos(i, j)] = neg_scale(acc, dinv);
         end
         for (int j = 0; j <= i; j++)
            inverse_queue.push_back(inv_word_type'{i[2:0], j[2:0],
                                    inv_copy[tri_pos(i, j)][31:0],
                                    zflag, (i == n - 1) && (j == i)});
      end
      typed_valid_q.push_back(w.check);
      typed_value_q.push_back(w.exp_value);
      typed_zero_q.push_back(w.exp_zero);
      inverses_done++;
   endtask

   // result checker: compare each strobed word against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         inv_word_type e;
         results_seen++;
         if (inverse_queue.size() == 0) begin
            $display("%0t ERROR unexpected word r%0d c%0d value %h", $time,
                     rsp_out_row, rsp_out_col, rsp_out_value);
            errors++;
         end else begin
            e = inverse_queue.pop_front();
            if ({rsp_out_row, rsp_out_col, rsp_out_value, rsp_zero_pivot, rsp_last_result}
                !== {e.row, e.col, e.value, e.zero, e.last}) begin
               $display("%0t ERROR expected r%0d c%0d v %h z%0d l%0d, got r%0d c%0d v %h z%0d l%0d",
                        $time, e.row, e.col, e.value, e.zero, e.last, rsp_out_row,
                        rsp_out_col, rsp_out_value, rsp_zero_pivot, rsp_last_result);
               errors++;
            end
            // typed-in directed expectation for the first word of an inversion
            if (e.row == 0 && e.col == 0 && typed_valid_q.size() > 0) begin
               if (typed_valid_q.pop_front() &&
                   {rsp_out_value, rsp_zero_pivot} !==
                   {typed_value_q[0], typed_zero_q[0]}) begin
                  $display("%0t ERROR table expected v %h z%0d, got v %h z%0d", $time,
                           typed_value_q[0], typed_zero_q[0], rsp_out_value, rsp_zero_pivot);
                  errors++;
               end
               void'(typed_value_q.pop_front());
               void'(typed_zero_q.pop_front());
            end
         end
      end
   end

   // watchdog: cycles with no word moving either way
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // drive one word at the falling edge, hold until accepted; start stays high
   // afterwards so that the next word can follow without a gap
   task automatic send_word(stim_row_type w);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      req_row_index     <= w.row;
      req_col_index     <= w.col;
      req_element_value <= w.value;
      req_last_element  <= w.last;
      start             <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_inverse(w);
      words_loaded++;
   endtask

   // size register write, only with the block drained
   task automatic write_order(logic [SIZE_W-1:0] v);
      @(negedge clock);
      start <= 1'b0;
      wait (inverse_queue.size() == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      order_reg    = v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // random lower matrix of order n, row-major; mostly well-conditioned diagonals
   task automatic send_matrix(int n);
      stim_row_type w;
      logic [31:0] v;
      for (int r = 0; r < n; r++) begin
         for (int c = 0; c <= r; c++) begin
            case ($urandom_range(9))
               0: v = 32'h0;
               1: v = $urandom;
               2: v = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
               3: v = $urandom_range(3);
               default: v = {{14{$urandom_range(1) ? 1'b1 : 1'b0}}, 18'($urandom)};
            endcase
            if (r == c && $urandom_range(15) != 0 && v == 0) v = 32'h0001_0000;
            w = '{r[2:0], c[2:0], v, (r == n - 1) && (c == r), 1'b0, 32'h0, 1'b0};
            send_word(w);
            // occasional noise word above the diagonal, ignored by the block
            if ($urandom_range(19) == 0) begin
               w = '{3'(r), 3'(r + 1 + $urandom_range(6 - (r > 6 ? 6 : r))), $urandom,
                     1'b0, 1'b0, 32'h0, 1'b0};
               if (w.col > w.row) send_word(w);
            end
         end
      end
   endtask

   stim_row_type directed_table [N_DIRECTED];
   int rand_order;

   initial begin
      errors = 0; words_loaded = 0; inverses_done = 0; results_seen = 0;
      idle_cycles = 0; send_idle_pct = 23; order_reg = SIZE_RESET;
      start = 1'b0; req_row_index = '0; req_col_index = '0;
      req_element_value = '0; req_last_element = 1'b0;
      csr_wr_en = 1'b0; csr_wr_data = '0;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // order 1: mostly a single diagonal word each, expected reciprocal typed in
      directed_table = '{
         '{3'd0, 3'd0, 32'h0001_0000, 1'b1, 1'b1, 32'h0001_0000, 1'b0},  // 1.0
         '{3'd0, 3'd0, 32'h0000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b1},  // zero pivot
         '{3'd0, 3'd0, 32'h0000_0001, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b0},  // tiny, saturates
         '{3'd0, 3'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h8000_0000, 1'b0},  // -tiny
         '{3'd0, 3'd0, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h0000_0002, 1'b0},  // max
         '{3'd0, 3'd0, 32'h8000_0000, 1'b1, 1'b1, 32'hFFFF_FFFE, 1'b0},  // min
         '{3'd0, 3'd0, 32'hFFFF_0000, 1'b1, 1'b1, 32'hFFFF_0000, 1'b0},  // -1.0
         '{3'd0, 3'd0, 32'h0002_0000, 1'b1, 1'b1, 32'h0000_8000, 1'b0},  // 2.0
         '{3'd0, 3'd3, 32'hDEAD_BEEF, 1'b0, 1'b0, 32'h0, 1'b0},          // above diag
         '{3'd7, 3'd7, 32'h1234_5678, 1'b0, 1'b0, 32'h0, 1'b0},          // outside order
         '{3'd5, 3'd6, 32'h0, 1'b1, 1'b1, 32'h0000_8000, 1'b0},          // ignored, last acts
         '{3'd0, 3'd0, 32'h0004_0000, 1'b1, 1'b1, 32'h0000_4000, 1'b0}   // 4.0
      };
      write_order(4'd1);
      for (int t = 0; t < N_DIRECTED; t++) send_word(directed_table[t]);

      // register extremes: 0 acts as 1, 15 acts as MAX_ORDER
      write_order(4'd0);
      send_matrix(1);
      write_order(4'd15);
      send_matrix(8);
      write_order(4'd2);
      send_matrix(2);

      // random phases: sender idles 23%, then 68%, then never
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = phase == 0 ? 23 : (phase == 1 ? 68 : 0);
         for (int m = 0; m < 10; m++) begin
            rand_order = $urandom_range(9) == 0 ? 8 : $urandom_range(1, 5);
            write_order(rand_order[SIZE_W-1:0]);
            send_matrix(rand_order);
         end
      end

      @(negedge clock);
      start <= 1'b0;
      wait (inverse_queue.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Loaded %0d words over %0d inversions, %0d inverse words checked.",
               words_loaded, inverses_done, results_seen);
      $display("Orders 0..15 register extremes, zero pivots, saturation and noise covered.");
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
